// ===== design/rlm_pkg.sv =====
`default_nettype none

package rlm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_SAMPLES = 4096;
    localparam int SUM_BITS    = 43;
    localparam int COUNT_BITS  = 13;
    localparam int RMS_BITS    = 16;
    localparam int SQ_BITS     = 2 * SAMPLE_BITS - 1;
    localparam int MEAN_BITS   = 2 * SAMPLE_BITS;
    localparam int QDEPTH      = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QLVL_BITS   = 3;
    localparam int DIV_STEPS   = SUM_BITS;
    localparam int SQRT_STEPS  = SAMPLE_BITS;
    localparam int STEP_BITS   = 6;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } sample_req_t;

    typedef struct packed {
        logic [RMS_BITS-1:0]   rms_level;
        logic [COUNT_BITS-1:0] sample_count;
        logic                  too_many;
    } result_t;

    typedef struct packed {
        logic [SUM_BITS-1:0]   sum;
        logic [COUNT_BITS-1:0] count;
        logic                  ovf;
    } blk_t;

    typedef struct packed {
        logic [QLVL_BITS-1:0] level;
        logic                 empty;
    } q_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_SQRT,
        BK_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ===== design/rlm_front.sv =====
`default_nettype none

module rlm_front
    import rlm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire sample_req_t item,
    output logic             full,
    input  wire q_status_t   q_stat,
    output logic             blk_valid,
    output blk_t             blk
);

    localparam logic [COUNT_BITS-1:0] MAX_C = COUNT_BITS'(MAX_SAMPLES);

    logic                      s1_valid_reg, s1_valid_next;
    logic                      s1_last_reg, s1_last_next;
    logic [SQ_BITS-1:0]        s1_sq_reg, s1_sq_next;
    logic [SUM_BITS-1:0]       sum_reg, sum_next, sum_acc;
    logic [COUNT_BITS-1:0]     count_reg, count_next, cnt_acc;
    logic                      ovf_reg, ovf_next, ovf_acc;
    logic signed [MEAN_BITS-1:0] prod;
    logic [QLVL_BITS:0]        pending;
    logic                      accept;

    assign pending = {1'b0, q_stat.level} + (QLVL_BITS+1)'(s1_valid_reg && s1_last_reg);
    assign full    = (pending >= (QLVL_BITS+1)'(QDEPTH));
    assign accept  = push && !full;
    assign prod    = item.sample * item.sample;

    always_comb
    begin
        s1_valid_next = accept;
        s1_last_next  = item.last;
        s1_sq_next    = prod[SQ_BITS-1:0];
    end

    // accumulate, or drop the sample once the block is saturated
    always_comb
    begin
        sum_acc = sum_reg;
        cnt_acc = count_reg;
        ovf_acc = ovf_reg;
        if (s1_valid_reg)
        begin
            if (count_reg < MAX_C)
            begin
                sum_acc = sum_reg + SUM_BITS'(s1_sq_reg);
                cnt_acc = count_reg + COUNT_BITS'(1);
            end
            else
            begin
                ovf_acc = 1'b1;
            end
        end
        blk_valid = s1_valid_reg && s1_last_reg;
        blk.sum   = sum_acc;
        blk.count = cnt_acc;
        blk.ovf   = ovf_acc;
        if (blk_valid)
        begin
            sum_next   = '0;
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else
        begin
            sum_next   = sum_acc;
            count_next = cnt_acc;
            ovf_next   = ovf_acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            sum_reg      <= '0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg <= s1_last_next;
            s1_sq_reg   <= s1_sq_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_C)
        else $error("block count beyond saturation");
    a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (count_reg == MAX_C))
        else $error("overflow flagged before count saturated");
`endif

endmodule

`default_nettype wire

// ===== design/rlm_queue.sv =====
`default_nettype none

module rlm_queue
    import rlm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr_en,
    input  wire blk_t      wr_data,
    input  wire logic      rd_en,
    output blk_t           rd_data,
    output q_status_t      stat
);

    blk_t                  mem [QDEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QLVL_BITS-1:0]  level_reg, level_next;
    logic                  do_rd;

    assign do_rd      = rd_en && (level_reg != '0);
    assign rd_data    = mem[rd_ptr_reg];
    assign stat.level = level_reg;
    assign stat.empty = (level_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
        level_next  = level_reg + QLVL_BITS'(wr_en) - QLVL_BITS'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef ASSERT_OFF
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (level_reg == QLVL_BITS'(QDEPTH)) |-> !wr_en)
        else $error("block queue written while full");
`endif

endmodule

`default_nettype wire

// ===== design/rlm_back.sv =====
`default_nettype none

module rlm_back
    import rlm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire q_status_t q_stat,
    input  wire blk_t      q_data,
    output logic           q_pop,
    input  wire logic      pop,
    output logic           empty,
    output result_t        result
);

    back_state_t            state_reg, state_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    logic [COUNT_BITS-1:0]  div_rem_reg, div_rem_next;
    logic [SUM_BITS-1:0]    div_quo_reg, div_quo_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic [MEAN_BITS-1:0]   srem_reg, srem_next;
    logic [MEAN_BITS-1:0]   root_reg, root_next;
    logic [MEAN_BITS-1:0]   bit_reg, bit_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                result_reg, result_next;
    logic [COUNT_BITS:0]    trial;
    logic                   trial_ge;
    logic [MEAN_BITS:0]     sq_trial;
    logic                   sq_ge;
    logic                   div_last, sqrt_last, out_free;

    assign trial     = {div_rem_reg, div_quo_reg[SUM_BITS-1]};
    assign trial_ge  = (trial >= {1'b0, count_reg});
    assign sq_trial  = {1'b0, root_reg} + {1'b0, bit_reg};
    assign sq_ge     = ({1'b0, srem_reg} >= sq_trial);
    assign div_last  = (step_reg == STEP_BITS'(DIV_STEPS - 1));
    assign sqrt_last = (step_reg == STEP_BITS'(SQRT_STEPS - 1));
    assign out_free  = !out_valid_reg || pop;
    assign empty     = !out_valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (!q_stat.empty) state_next = BK_DIV;
            BK_DIV:  if (div_last)      state_next = BK_SQRT;
            BK_SQRT: if (sqrt_last)     state_next = BK_DONE;
            BK_DONE: if (out_free)      state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop          = 1'b0;
        step_next      = step_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg && !pop;
        result_next    = result_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop        = 1'b1;
                    step_next    = '0;
                    div_rem_next = '0;
                    div_quo_next = q_data.sum;
                    count_next   = q_data.count;
                    ovf_next     = q_data.ovf;
                end
            end
            BK_DIV:
            begin
                // restoring division, one quotient bit a cycle
                if (trial_ge)
                begin
                    div_rem_next = COUNT_BITS'(trial - {1'b0, count_reg});
                end
                else
                begin
                    div_rem_next = trial[COUNT_BITS-1:0];
                end
                div_quo_next = {div_quo_reg[SUM_BITS-2:0], trial_ge};
                step_next    = step_reg + STEP_BITS'(1);
                if (div_last)
                begin
                    step_next = '0;
                    srem_next = (count_reg == '0) ? '0
                              : {div_quo_reg[MEAN_BITS-2:0], trial_ge};
                    root_next = '0;
                    bit_next  = MEAN_BITS'(1) << (MEAN_BITS - 2);
                end
            end
            BK_SQRT:
            begin
                // bit-by-bit square root, two radicand bits a cycle
                if (sq_ge)
                begin
                    srem_next = srem_reg - sq_trial[MEAN_BITS-1:0];
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                step_next = step_reg + STEP_BITS'(1);
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    result_next.rms_level    = root_reg[RMS_BITS-1:0];
                    result_next.sample_count = count_reg;
                    result_next.too_many     = ovf_reg;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        count_reg   <= count_next;
        ovf_reg     <= ovf_next;
        srem_reg    <= srem_next;
        root_reg    <= root_next;
        bit_reg     <= bit_next;
        result_reg  <= result_next;
    end

`ifndef ASSERT_OFF
    a_ovf_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.too_many)
        |-> (result_reg.sample_count == COUNT_BITS'(MAX_SAMPLES)))
        else $error("overflow result without saturated count");
`endif

endmodule

`default_nettype wire

// ===== design/block_rms_level_meter_core.sv =====
`default_nettype none

// Block RMS level meter. Takes one signed Q1.15 sample per cycle while full is
// low: a request is squared in one stage and accumulated in the next. A sample
// marked last closes the block and hands its sum, count and overflow flag to a
// four-entry block queue. Behind the queue a restoring divider produces the
// mean, a bit-by-bit square root follows, and the result is loaded into an
// output register. The back end takes one block at a time, so blocks that end
// faster than it finishes them queue up, and full rises while the queue holds
// no room for block ends still in flight. Samples beyond 4096 in a block are
// dropped and flagged in too_many. No clearing pass is needed after reset.
module block_rms_level_meter_core
    import rlm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire sample_req_t item,
    output logic             empty,
    input  wire logic        pop,
    output result_t          result
);

    logic      blk_valid;
    blk_t      blk;
    blk_t      q_data;
    q_status_t q_stat;
    logic      q_pop;

    rlm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .q_stat    (q_stat),
        .blk_valid (blk_valid),
        .blk       (blk)
    );

    rlm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (blk_valid),
        .wr_data (blk),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .stat    (q_stat)
    );

    rlm_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .q_data (q_data),
        .q_pop  (q_pop),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

endmodule

`default_nettype wire
